// File: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/nwc_pkg.sv
// Package with shared types and constants of the necklace word classifier.
package nwc_pkg;

	localparam int DEFAULT_MAX_LENGTH = 16;
	localparam int RESET_LENGTH       = 16;
	localparam int CFG_W              = 5;

	typedef enum logic [1:0] {
		STATUS_KEPT    = 2'd0,
		STATUS_ROTATED = 2'd1,
		STATUS_VANISH  = 2'd2
	} status_t;

	// Running verdict that travels down the rotation chain with each word.
	typedef struct packed {
		logic smallest;
		logic found;
		logic low_par;
		logic pre_par;
		logic tot_par;
	} nwc_flags_t;

endpackage

// File: hw/rtl/nwc_cell.sv
// One rotation cell: rotates the word by one more place and updates the verdict.
module nwc_cell #(
	parameter int MAX_LENGTH = 16,
	parameter int LEN_W      = $clog2(MAX_LENGTH + 1),
	parameter int IDX        = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [LEN_W-1:0]       len,
	input  logic                   in_valid,
	input  logic [MAX_LENGTH-1:0]  in_word,
	input  logic [MAX_LENGTH-1:0]  in_rot,
	input  nwc_pkg::nwc_flags_t    in_flags,
	output logic                   out_valid,
	output logic [MAX_LENGTH-1:0]  out_word,
	output logic [MAX_LENGTH-1:0]  out_rot,
	output nwc_pkg::nwc_flags_t    out_flags
);
	import nwc_pkg::*;

	logic                  active;
	logic [MAX_LENGTH-1:0] rot_nxt;
	nwc_flags_t            flags_nxt;
	logic                  valid_s1;
	logic [MAX_LENGTH-1:0] word_s1;
	logic [MAX_LENGTH-1:0] rot_s1;
	nwc_flags_t            flags_s1;

	// Cells at or beyond the configured length make no comparison; smallest, found and low_par pass through unchanged.
	assign active = LEN_W'(IDX) < len;

	always_comb begin
		rot_nxt = in_rot >> 1;
		for (int b = 0; b < MAX_LENGTH; b++) begin
			if (LEN_W'(b) == len - LEN_W'(1)) begin
				rot_nxt[b] = in_rot[0];
			end
		end
	end

	always_comb begin
		flags_nxt = in_flags;
		// Parity of the low IDX bits, ready in case IDX turns out to be the period.
		flags_nxt.pre_par = in_flags.pre_par ^ in_word[IDX-1];
		if (active) begin
			if (rot_nxt < in_word) begin
				flags_nxt.smallest = 1'b0;
			end
			if (rot_nxt == in_word && !in_flags.found) begin
				flags_nxt.found   = 1'b1;
				flags_nxt.low_par = flags_nxt.pre_par;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s1  <= in_word;
		rot_s1   <= rot_nxt;
		flags_s1 <= flags_nxt;
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;
	assign out_rot   = rot_s1;
	assign out_flags = flags_s1;

endmodule

// File: hw/rtl/necklace_word_classify_top.sv
// Top level of the necklace word classifier: input stage, rotation chain, result stage.
//
// Classifies one word per clock under cyclic rotation. A request is taken when
// start is high and busy is low; busy is high only in the first cycle after
// reset, so a request may be issued in every cycle after that. The result for a
// request appears on status and odd_parity after the input register, the chain
// of MAX_LENGTH - 1 rotation cells (each comparing one rotation of the word) and
// the result register, marked by done for exactly one cycle, in request order.
// The receiver cannot hold results off: done must be sampled whenever it is high.
// word_length is written through the cfg channel (0 means 1, values above
// MAX_LENGTH saturate) and must only change while no request is in flight.
`include "assert_macros.svh"

module necklace_word_classify_top #(
	parameter int MAX_LENGTH = nwc_pkg::DEFAULT_MAX_LENGTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [MAX_LENGTH-1:0]       word,
	output logic                        busy,
	output logic                        done,
	output logic [1:0]                  status,
	output logic                        odd_parity,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nwc_pkg::CFG_W-1:0]   cfg_data
);
	import nwc_pkg::*;

	localparam int LEN_W = $clog2(MAX_LENGTH + 1);
	localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
	localparam logic [LEN_W-1:0] LEN_RESET =
		LEN_W'((MAX_LENGTH < RESET_LENGTH) ? MAX_LENGTH : RESET_LENGTH);

	logic                  busy_q;
	logic [LEN_W-1:0]      len_q;
	logic                  accept;
	logic [CMP_W-1:0]      cfg_ext;
	logic [LEN_W-1:0]      len_eff;
	logic [MAX_LENGTH-1:0] word_masked;

	logic                  valid_s0;
	logic [MAX_LENGTH-1:0] word_s0;
	nwc_flags_t            flags_s0;
	nwc_flags_t            flags_init;

	logic                  ch_valid [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] ch_word  [MAX_LENGTH];
	logic [MAX_LENGTH-1:0] ch_rot   [MAX_LENGTH];
	nwc_flags_t            ch_flags [MAX_LENGTH];

	nwc_flags_t            last_flags;
	logic                  low_eff;
	status_t               status_nxt;
	logic                  done_q;
	status_t               status_q;
	logic                  odd_parity_q;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;

	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == CMP_W'(0)) begin
			len_eff = LEN_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_LENGTH)) begin
			len_eff = LEN_W'(MAX_LENGTH);
		end else begin
			len_eff = LEN_W'(cfg_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b1;
			len_q    <= LEN_RESET;
			valid_s0 <= 1'b0;
		end else begin
			busy_q   <= 1'b0;
			valid_s0 <= accept;
			if (cfg_valid && cfg_ready) begin
				len_q <= len_eff;
			end
		end
	end

	always_comb begin
		for (int b = 0; b < MAX_LENGTH; b++) begin
			word_masked[b] = word[b] && (LEN_W'(b) < len_q);
		end
		flags_init          = '0;
		flags_init.smallest = 1'b1;
		flags_init.tot_par  = ^word_masked;
	end

	always_ff @(posedge clk) begin
		word_s0  <= word_masked;
		flags_s0 <= flags_init;
	end

	assign ch_valid[0] = valid_s0;
	assign ch_word[0]  = word_s0;
	assign ch_rot[0]   = word_s0;
	assign ch_flags[0] = flags_s0;

	for (genvar j = 1; j < MAX_LENGTH; j++) begin : g_cell
		nwc_cell #(
			.MAX_LENGTH (MAX_LENGTH),
			.LEN_W      (LEN_W),
			.IDX        (j)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.len       (len_q),
			.in_valid  (ch_valid[j-1]),
			.in_word   (ch_word[j-1]),
			.in_rot    (ch_rot[j-1]),
			.in_flags  (ch_flags[j-1]),
			.out_valid (ch_valid[j]),
			.out_word  (ch_word[j]),
			.out_rot   (ch_rot[j]),
			.out_flags (ch_flags[j])
		);
	end

	assign last_flags = ch_flags[MAX_LENGTH-1];

	always_comb begin
		// Without a shorter period the period is the whole word.
		low_eff = last_flags.found ? last_flags.low_par : last_flags.tot_par;
		if (!last_flags.smallest) begin
			status_nxt = STATUS_ROTATED;
		end else if (!last_flags.tot_par && low_eff) begin
			status_nxt = STATUS_VANISH;
		end else begin
			status_nxt = STATUS_KEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ch_valid[MAX_LENGTH-1];
		end
	end

	always_ff @(posedge clk) begin
		status_q     <= status_nxt;
		odd_parity_q <= last_flags.tot_par;
	end

	assign done       = done_q;
	assign status     = status_q;
	assign odd_parity = odd_parity_q;

	`ASSERT_IMPL(a_latency_fwd, clk, arst_n, accept, ##(MAX_LENGTH + 1) done)
	`ASSERT_IMPL(a_latency_back, clk, arst_n, done, $past(accept, MAX_LENGTH + 1))
	`ASSERT_IMPL(a_vanish_even, clk, arst_n, done && (status == STATUS_VANISH), !odd_parity)

endmodule
